// ===== hdl/irac_pkg.sv =====
// Shared types, constants and helpers for the radix-to-ASCII converter.
// Depends on nothing; every other file of the block imports it.
package irac_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int DIGIT_DEPTH = 64;
    localparam int NCELLS      = (VALUE_WIDTH + 3) / 4;
    localparam int VALUE_EXT_W = NCELLS * 4;
    localparam int IDX_W       = $clog2(DIGIT_DEPTH);

    localparam int RADIX_W     = 5;
    localparam int RADIX_LSB   = 64;
    localparam int S_TDATA_W   = 72;
    localparam int CHAR_W      = 7;
    localparam int M_TDATA_W   = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_A    = 7'd65;
    localparam logic [3:0]        DEC_BASE   = 4'd10;

    typedef struct packed {
        logic       en;
        logic [3:0] rem;
    } t_link;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

    function automatic logic [CHAR_W-1:0] ascii_of(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_BASE) begin
            c = ASCII_ZERO + CHAR_W'(d);
        end else begin
            c = ASCII_A + CHAR_W'(d - DEC_BASE);
        end
        return c;
    endfunction

endpackage

// ===== hdl/irac_cell.sv =====
// One nibble cell of the division row: divides {incoming remainder, nibble} by the radix.
// Depends on irac_pkg for the link type between neighboring cells.
module irac_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic [3:0]                i_nib,
    input  logic [4:0]                i_radix,
    input  irac_pkg::t_link           i_link,
    output irac_pkg::t_link           o_link,
    output logic [3:0]                o_nib
);
    import irac_pkg::*;

    logic [3:0] r_nib;
    logic       r_en;
    logic [3:0] r_rem;
    logic [3:0] w_q;
    logic [3:0] w_acc;
    logic [4:0] w_t;

    always_comb begin
        w_acc = i_link.rem;
        w_q   = '0;
        w_t   = '0;
        for (int b = 3; b >= 0; b--) begin
            w_t = {w_acc, r_nib[b]};
            if (w_t >= i_radix) begin
                w_q[b] = 1'b1;
                w_acc  = 4'(w_t - i_radix);
            end else begin
                w_acc  = w_t[3:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0;
        end else if (i_load) begin
            r_en <= 1'b0;
        end else begin
            r_en <= i_link.en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_nib <= i_nib;
        end else if (i_link.en) begin
            r_nib <= w_q;
            r_rem <= w_acc;
        end
    end

    assign o_link = '{en: r_en, rem: r_rem};
    assign o_nib  = r_nib;

endmodule

// ===== hdl/irac_chain.sv =====
// Row of nibble cells; the most significant cell takes the feed, cell zero yields digits.
// Depends on irac_pkg and irac_cell.
module irac_chain (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic [irac_pkg::VALUE_EXT_W-1:0]    i_value,
    input  logic [4:0]                          i_radix,
    input  irac_pkg::t_link                     i_feed,
    output irac_pkg::t_link                     o_digit,
    output logic                                o_nonzero
);
    import irac_pkg::*;

    t_link      w_link [NCELLS+1];
    logic [3:0] w_nib  [NCELLS];
    logic [NCELLS-1:0] w_nz;

    assign w_link[NCELLS] = i_feed;

    for (genvar j = 0; j < NCELLS; j++) begin : g_cell
        irac_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (i_load),
            .i_nib   (i_value[4*j +: 4]),
            .i_radix (i_radix),
            .i_link  (w_link[j+1]),
            .o_link  (w_link[j]),
            .o_nib   (w_nib[j])
        );
        assign w_nz[j] = |w_nib[j];
    end

    assign o_digit   = w_link[0];
    assign o_nonzero = |w_nz;

endmodule

// ===== hdl/integer_to_radix_ascii.sv =====
// A request passes through the division row until all DIGIT_DEPTH digits are stored, then
// one character per cycle follows while m_tready allows, 1 to 64 characters, through a
// store read register and an output register. One request is taken at a time; the row
// length sets the fill time and the store's single read port sets the emit rate.
// Reset (synchronous, active low) returns the controller to idle and drops all valid flags.
// Depends on irac_pkg and irac_chain.
module integer_to_radix_ascii (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [irac_pkg::S_TDATA_W-1:0]  s_tdata,   // value [63:0], radix [68:64], zeros
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [irac_pkg::M_TDATA_W-1:0]  m_tdata,   // digit_char [6:0], zero [7]
    output logic                            m_tlast
);
    import irac_pkg::*;

    t_state               r_state;
    t_state               n_state;
    logic [RADIX_W-1:0]   r_radix;
    logic [RADIX_W-1:0]   w_radix_in;
    logic                 w_accept;
    logic                 w_idle;
    logic                 r_feeding;
    logic [IDX_W-1:0]     r_feed_cnt;
    logic [IDX_W-1:0]     r_wr_idx;
    logic [IDX_W-1:0]     r_high;
    logic [IDX_W-1:0]     w_high_now;
    logic                 w_div_done;
    t_link                w_feed;
    t_link                w_dig;
    logic                 w_nonzero;
    logic [3:0]           r_store [DIGIT_DEPTH];
    logic [IDX_W-1:0]     r_rd_idx;
    logic                 r_rd_more;
    logic [3:0]           r_q_dig;
    logic                 r_q_last;
    logic                 r_qv;
    logic                 w_move;
    logic                 w_issue;
    logic                 r_m_valid;
    logic [CHAR_W-1:0]    r_m_char;
    logic                 r_m_last;

    always_comb begin
        w_radix_in = s_tdata[RADIX_LSB +: RADIX_W];
        if (w_radix_in < RADIX_MIN) begin
            w_radix_in = RADIX_MIN;
        end else if (w_radix_in > RADIX_MAX) begin
            w_radix_in = RADIX_MAX;
        end
    end

    assign w_accept   = s_tvalid && s_tready;
    assign w_feed     = '{en: r_feeding, rem: 4'd0};
    assign w_div_done = w_dig.en && (r_wr_idx == IDX_W'(DIGIT_DEPTH - 1));
    assign w_high_now = (w_dig.en && (w_dig.rem != 4'd0)) ? r_wr_idx : r_high;

    irac_chain u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_accept),
        .i_value   (VALUE_EXT_W'(s_tdata[VALUE_WIDTH-1:0])),
        .i_radix   (r_radix),
        .i_feed    (w_feed),
        .o_digit   (w_dig),
        .o_nonzero (w_nonzero)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_rd_more && !r_qv) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_idle = 1'b0;
        unique case (r_state)
            S_IDLE:  w_idle = 1'b1;
            S_DIV:   w_idle = 1'b0;
            S_EMIT:  w_idle = 1'b0;
            default: w_idle = 1'b0;
        endcase
    end

    assign s_tready = w_idle;
    assign w_move   = r_qv && (!r_m_valid || m_tready);
    assign w_issue  = (r_state == S_EMIT) && r_rd_more && (!r_qv || w_move);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_feeding  <= 1'b0;
            r_feed_cnt <= '0;
            r_wr_idx   <= '0;
            r_high     <= '0;
            r_rd_more  <= 1'b0;
            r_qv       <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_feeding  <= 1'b1;
                r_feed_cnt <= '0;
                r_wr_idx   <= '0;
                r_high     <= '0;
            end else begin
                if (r_feeding) begin
                    r_feed_cnt <= r_feed_cnt + 1'b1;
                    if (r_feed_cnt == IDX_W'(DIGIT_DEPTH - 1)) r_feeding <= 1'b0;
                end
                if (w_dig.en) begin
                    r_wr_idx <= r_wr_idx + 1'b1;
                    r_high   <= w_high_now;
                end
            end
            if (w_div_done) begin
                r_rd_more <= 1'b1;
            end else if (w_issue && (r_rd_idx == '0)) begin
                r_rd_more <= 1'b0;
            end
            if (w_issue) begin
                r_qv <= 1'b1;
            end else if (w_move) begin
                r_qv <= 1'b0;
            end
            if (w_move) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_radix <= w_radix_in;
        end
        if (w_dig.en) begin
            r_store[r_wr_idx] <= w_dig.rem;
        end
        if (w_div_done) begin
            r_rd_idx <= w_nonzero ? IDX_W'(DIGIT_DEPTH - 1) : w_high_now;
        end else if (w_issue) begin
            r_rd_idx <= r_rd_idx - 1'b1;
        end
        if (w_issue) begin
            r_q_dig  <= r_store[r_rd_idx];
            r_q_last <= (r_rd_idx == '0);
        end
        if (w_move) begin
            r_m_char <= ascii_of(r_q_dig);
            r_m_last <= r_q_last;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = M_TDATA_W'(r_m_char);
    assign m_tlast  = r_m_last;

    a_q_only_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_EMIT) |-> !r_qv)
        else $error("Read stage holds a digit outside the emit phase.");

    a_digit_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dig.en |-> (r_state == S_DIV))
        else $error("Division row produced a digit outside the division phase.");

    a_feed_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_feeding)
        else $error("Division feed did not start after an accepted request.");

    a_feed_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_feeding |-> (r_state == S_DIV))
        else $error("Division feed active outside the division phase.");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for integer_to_radix_ascii: it drives value/radix requests and
// checks every ASCII digit and its last flag against a digit predictor in the bench.
// Depends on irac_pkg and the integer_to_radix_ascii RTL.
`timescale 1ns / 100ps

module testbench;
    import irac_pkg::*;

    localparam int RESET_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 200;
    localparam int CALM_FROM      = 160;
    localparam int HOLD_AT        = 50;
    localparam int DRAIN_AT       = 120;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } digit_char_t;

    class digit_scoreboard;
        digit_char_t expected_chars[$];
        int errors;
        int checked;
        int requests;

        function new();
            errors   = 0;
            checked  = 0;
            requests = 0;
        endfunction

        function void note_request(logic [63:0] value, logic [RADIX_W-1:0] radix);
            logic [63:0]        rest;
            logic [RADIX_W-1:0] base;
            logic [3:0]         digits [DIGIT_DEPTH];
            int                 n;
            digit_char_t        c;
            base = radix;
            if (base < RADIX_MIN) begin
                base = RADIX_MIN;
            end
            if (base > RADIX_MAX) begin
                base = RADIX_MAX;
            end
            rest = value;
            n    = 0;
            while (rest != 0) begin
                if (n < DIGIT_DEPTH) begin
                    digits[n] = 4'(rest % base);
                    n++;
                end
                rest = rest / base;
            end
            if (n == 0) begin
                digits[0] = 4'd0;
                n = 1;
            end
            for (int k = n - 1; k >= 0; k--) begin
                if (digits[k] < DEC_BASE) begin
                    c.ch = ASCII_ZERO + CHAR_W'(digits[k]);
                end else begin
                    c.ch = ASCII_A + CHAR_W'(digits[k] - DEC_BASE);
                end
                c.last = (k == 0);
                expected_chars.push_back(c);
            end
            requests++;
        endfunction

        function void check_char(logic [M_TDATA_W-1:0] data, logic last);
            digit_char_t c;
            checked++;
            if (expected_chars.size() == 0) begin
                $error("unexpected character: got digit_char %0d last %0b", data[CHAR_W-1:0],
                       last);
                errors++;
                return;
            end
            c = expected_chars.pop_front();
            if (data[CHAR_W-1:0] !== c.ch) begin
                $error("digit_char: expected %0d, got %0d", c.ch, data[CHAR_W-1:0]);
                errors++;
            end
            if (data[M_TDATA_W-1] !== 1'b0) begin
                $error("tdata pad: expected 0, got %0b", data[M_TDATA_W-1]);
                errors++;
            end
            if (last !== c.last) begin
                $error("last: expected %0b, got %0b", c.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // value [63:0], radix [68:64], zeros [71:69]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // digit_char [6:0], zero [7]
    logic                 m_tlast;

    digit_scoreboard board;
    bit              calm;
    bit              hold_off_req;
    int              idle_cycles;

    integer_to_radix_ascii dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge i_clk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            board.check_char(m_tdata, m_tlast);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(input logic [63:0] value, input logic [RADIX_W-1:0] radix,
                                input int gap);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tdata  = {3'b000, radix, value};
        s_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        board.note_request(value, radix);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            1: v = v >> $urandom_range(1, 63);
            2: v = 64'($urandom_range(0, 255));
            3: v = ~(v >> $urandom_range(0, 8));
            default: ;
        endcase
        return v;
    endfunction

    initial begin
        int                 gap;
        logic [RADIX_W-1:0] radix;
        board        = new();
        calm         = 1'b0;
        hold_off_req = 1'b0;
        idle_cycles  = 0;
        i_rst_n      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_request(64'd0, 5'd10, 0);
        send_request(64'd0, 5'd2, 0);
        send_request(64'd1, 5'd2, 0);
        send_request('1, 5'd2, 0);
        send_request('1, 5'd16, 0);
        send_request('1, 5'd10, 0);
        send_request('1, 5'd3, 0);
        send_request(64'h8000_0000_0000_0000, 5'd2, 0);
        send_request(64'h0123_4567_89AB_CDEF, 5'd16, 0);
        send_request(64'd15, 5'd16, 0);
        send_request(64'd10_000_000_000_000_000_000, 5'd10, 0);
        send_request(64'd9_999_999_999_999_999_999, 5'd10, 0);
        send_request(64'd12345, 5'd0, 0);
        send_request(64'd12345, 5'd1, 0);
        send_request(64'hFEDC_BA98_7654_3210, 5'd17, 0);
        send_request(64'hFEDC_BA98_7654_3210, 5'd31, 0);
        send_request(64'd14, 5'd15, 0);
        send_request(64'd7, 5'd7, 0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == CALM_FROM) begin
                calm = 1'b1;
            end
            if (i == HOLD_AT) begin
                hold_off_req = 1'b1;
            end
            if (i == DRAIN_AT) begin
                s_tvalid = 1'b0;
                while (board.pending() != 0) @(negedge i_clk);
            end
            gap = (!calm && $urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
            if ($urandom_range(0, 9) == 0) begin
                radix = RADIX_W'($urandom_range(0, 31));
            end else begin
                radix = RADIX_W'($urandom_range(2, 16));
            end
            send_request(random_value(), radix, gap);
        end
        s_tvalid = 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Converted %0d values and checked %0d characters, with radix clamping,",
                 board.requests, board.checked);
        $display("random stalls on both sides, a long output hold-off and an input pause.");
        if (board.errors == 0 && board.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
